>>> rtl/dkat_pkg.sv
// Shared types, widths and codes for the date-keyed accumulate table.
package dkat_pkg;

  localparam int CAPACITY = 64;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  localparam int YEAR_W  = 12;
  localparam int MONTH_W = 4;
  localparam int DAY_W   = 5;
  localparam int ADD_W   = 8;
  localparam int HOURS_W = 16;

  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 40;
  localparam int TUSER_W     = 2;

  localparam logic [HOURS_W-1:0] HOURS_MAX = '1;

  // Request kinds.
  localparam logic [1:0] REQ_ADD    = 2'd0;
  localparam logic [1:0] REQ_LOOKUP = 2'd1;
  localparam logic [1:0] REQ_MAX    = 2'd2;

  // Result status codes.
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_APPENDED  = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;
  localparam logic [1:0] ST_NOT_FOUND = 2'd3;

  typedef struct packed {
    logic                justified;
    logic [HOURS_W-1:0]  hours;
    logic [DAY_W-1:0]    day;
    logic [MONTH_W-1:0]  month;
    logic [YEAR_W-1:0]   year;
  } rec_t;

endpackage

>>> rtl/date_keyed_accumulate_table.sv
// Date-keyed accumulate table: record memory, scan sequencer and output register.
//
// Usage: one request beat enters on the in_ channel (in_tuser = request kind,
// in_tdata = date key, hours and flag). Every request returns exactly one
// result beat on the out_ channel (out_tuser = status, out_tdata = record).
// Add merges hours into the record with an equal date (saturating at 65535)
// or appends a new record; lookup returns the record for a date; max returns
// the first unflagged record with the most hours.
// The records sit in one single-port-write, one-read synchronous memory with
// a registered read. An add, lookup or max request walks the stored records
// one per cycle through a two-stage read/compare pipeline; an add or lookup
// stops at the first equal date. With a free output register, in_tready
// returns in the same cycle that the result beat becomes valid.
// The next request is accepted as soon as the previous result has moved into
// the output register, even while that result still waits for out_tready.
// If the receiver stalls, the finished result holds in the sequencer until
// the output register frees up, and in_tready stays low meanwhile.
// Reset (rst_n low, synchronous) empties the table by clearing the record
// count; the memory itself needs no clearing pass, since only records below
// the count are ever examined.
module date_keyed_accumulate_table (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // [11:0] year, [15:12] month, [20:16] day, [28:21] hours, [29] justified
  input  logic [dkat_pkg::IN_TDATA_W-1:0]    in_tdata,
  // [1:0] req_type
  input  logic [dkat_pkg::TUSER_W-1:0]       in_tuser,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // [11:0] out_year, [15:12] out_month, [20:16] out_day, [36:21] out_hours,
  // [37] out_justified
  output logic [dkat_pkg::OUT_TDATA_W-1:0]   out_tdata,
  // [1:0] status
  output logic [dkat_pkg::TUSER_W-1:0]       out_tuser
);
  import dkat_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_EMIT
  } state_t;

  // Record memory.
  rec_t              mem [CAPACITY];
  rec_t              rd_data_r;
  logic [IDX_W-1:0]  rd_addr;
  logic              mem_we;
  logic [IDX_W-1:0]  mem_wa;
  rec_t              mem_wd;

  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [CNT_W-1:0]  issue_r, issue_nxt;
  logic              chk_vld_r, chk_vld_nxt;
  logic [IDX_W-1:0]  chk_idx_r, chk_idx_nxt;
  logic [1:0]        req_r, req_nxt;
  rec_t              key_r, key_nxt;
  logic              best_vld_r, best_vld_nxt;
  rec_t              best_r, best_nxt;
  logic [1:0]        res_st_r, res_st_nxt;
  rec_t              res_r, res_nxt;
  logic              out_vld_r, out_vld_nxt;
  logic [1:0]        out_st_r, out_st_nxt;
  rec_t              out_rec_r, out_rec_nxt;

  logic              key_hit;
  logic [HOURS_W:0]  sum;
  logic [HOURS_W-1:0] sat_hours;
  rec_t              in_rec;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_vld_r;
  assign out_tuser  = out_st_r;
  assign out_tdata  = {{(OUT_TDATA_W - $bits(rec_t)){1'b0}}, out_rec_r};

  always_comb begin
    in_rec.year      = in_tdata[11:0];
    in_rec.month     = in_tdata[15:12];
    in_rec.day       = in_tdata[20:16];
    in_rec.hours     = {{(HOURS_W - ADD_W){1'b0}}, in_tdata[28:21]};
    in_rec.justified = in_tdata[29];
  end

  assign key_hit = (rd_data_r.year == key_r.year) && (rd_data_r.month == key_r.month) &&
                   (rd_data_r.day == key_r.day);
  assign sum       = {1'b0, rd_data_r.hours} + {1'b0, key_r.hours};
  assign sat_hours = sum[HOURS_W] ? HOURS_MAX : sum[HOURS_W-1:0];
  assign rd_addr   = issue_r[IDX_W-1:0];

  always_comb begin
    state_nxt    = state_r;
    count_nxt    = count_r;
    issue_nxt    = issue_r;
    chk_vld_nxt  = chk_vld_r;
    chk_idx_nxt  = chk_idx_r;
    req_nxt      = req_r;
    key_nxt      = key_r;
    best_vld_nxt = best_vld_r;
    best_nxt     = best_r;
    res_st_nxt   = res_st_r;
    res_nxt      = res_r;
    out_vld_nxt  = out_vld_r;
    out_st_nxt   = out_st_r;
    out_rec_nxt  = out_rec_r;
    mem_we       = 1'b0;
    mem_wa       = chk_idx_r;
    mem_wd       = key_r;

    if (out_vld_r && out_tready) begin
      out_vld_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          req_nxt      = in_tuser;
          key_nxt      = in_rec;
          issue_nxt    = '0;
          chk_vld_nxt  = 1'b0;
          best_vld_nxt = 1'b0;
          if (in_tuser == REQ_ADD || in_tuser == REQ_LOOKUP || in_tuser == REQ_MAX) begin
            state_nxt = S_SCAN;
          end else begin
            res_st_nxt = ST_NOT_FOUND;
            res_nxt    = '0;
            state_nxt  = S_EMIT;
          end
        end
      end

      S_SCAN: begin
        // Stage one: issue the next read while records remain.
        chk_vld_nxt = (issue_r < count_r);
        chk_idx_nxt = issue_r[IDX_W-1:0];
        if (issue_r < count_r) begin
          issue_nxt = issue_r + 1'b1;
        end

        // Stage two: examine the record read in the previous cycle.
        if (chk_vld_r) begin
          if (req_r == REQ_MAX) begin
            if (!rd_data_r.justified &&
                (!best_vld_r || (rd_data_r.hours > best_r.hours))) begin
              best_vld_nxt = 1'b1;
              best_nxt     = rd_data_r;
            end
          end else if (key_hit) begin
            res_st_nxt = ST_OK;
            res_nxt    = rd_data_r;
            if (req_r == REQ_ADD) begin
              res_nxt.hours = sat_hours;
              mem_we        = 1'b1;
              mem_wa        = chk_idx_r;
              mem_wd        = rd_data_r;
              mem_wd.hours  = sat_hours;
            end
            state_nxt = S_EMIT;
          end
        end else if (issue_r == count_r) begin
          // Every record has been examined without an early match.
          state_nxt = S_EMIT;
          if (req_r == REQ_MAX) begin
            res_st_nxt = best_vld_r ? ST_OK : ST_NOT_FOUND;
            res_nxt    = best_vld_r ? best_r : '0;
          end else if (req_r == REQ_LOOKUP) begin
            res_st_nxt = ST_NOT_FOUND;
            res_nxt    = '0;
          end else if (count_r < CNT_W'(CAPACITY)) begin
            mem_we     = 1'b1;
            mem_wa     = count_r[IDX_W-1:0];
            mem_wd     = key_r;
            count_nxt  = count_r + 1'b1;
            res_st_nxt = ST_APPENDED;
            res_nxt    = key_r;
          end else begin
            res_st_nxt = ST_FULL;
            res_nxt    = '0;
          end
        end
      end

      S_EMIT: begin
        if (!out_vld_r || out_tready) begin
          out_vld_nxt = 1'b1;
          out_st_nxt  = res_st_r;
          out_rec_nxt = res_r;
          state_nxt   = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      count_r    <= '0;
      issue_r    <= '0;
      chk_vld_r  <= 1'b0;
      best_vld_r <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      count_r    <= count_nxt;
      issue_r    <= issue_nxt;
      chk_vld_r  <= chk_vld_nxt;
      best_vld_r <= best_vld_nxt;
      out_vld_r  <= out_vld_nxt;
    end
    chk_idx_r <= chk_idx_nxt;
    req_r     <= req_nxt;
    key_r     <= key_nxt;
    best_r    <= best_nxt;
    res_st_r  <= res_st_nxt;
    res_r     <= res_nxt;
    out_st_r  <= out_st_nxt;
    out_rec_r <= out_rec_nxt;
  end

endmodule

>>> tb/tb_date_keyed_accumulate_table.sv
`timescale 1ns / 1ps
// Self-checking testbench for the date-keyed accumulate table, with its own table predictor.
module tb_date_keyed_accumulate_table;
  import dkat_pkg::*;

  // The block answers the fourth request kind with a not-found result and no state change.
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  localparam int HOT_ITEMS    = 300;   // Merges into one key, enough to saturate its hours.
  localparam int MIX_ITEMS    = 500;   // Mixed traffic that fills the table and runs past full.
  localparam int KEY_POOL     = 96;    // More keys than CAPACITY, so the table fills.
  localparam int CALM_FROM    = 60;    // Request count range in which neither side idles.
  localparam int CALM_TO      = 260;
  localparam int HOLD_AT      = 450;   // Request count at which the receiver holds off.
  localparam int HOLD_CYCLES  = 300;
  localparam int IDLE_LIMIT   = 5000;  // Cycles with no beat at all before the run is abandoned.
  localparam int DRAIN_CYCLES = CAPACITY + 8;
  localparam int PRINT_CAP    = 20;

  typedef struct packed {
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
  } date_t;

  typedef struct packed {
    logic [1:0]         kind;
    date_t              key;
    logic [ADD_W-1:0]   hours;
    logic               justified;
  } req_t;

  typedef struct packed {
    logic [1:0] status;
    rec_t       rec;
  } reply_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic [TUSER_W-1:0]     in_tuser = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [TUSER_W-1:0]     out_tuser;

  date_keyed_accumulate_table dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always #1 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Predictor: a copy of the record table, updated once per accepted request.
  // ---------------------------------------------------------------------------
  rec_t ledger [CAPACITY];
  int   ledger_fill = 0;

  function automatic reply_t apply_request(req_t r);
    reply_t           rep;
    int               hit;
    int               best;
    logic [HOURS_W:0] total;
    rep = '0;
    rep.status = ST_NOT_FOUND;
    hit = -1;
    best = -1;
    // The first record with an equal key wins; the first unflagged record with
    // strictly more hours replaces the current best, so ties keep the lowest index.
    for (int k = 0; k < ledger_fill; k++) begin
      if (hit < 0 && ledger[k].year == r.key.year && ledger[k].month == r.key.month &&
          ledger[k].day == r.key.day)
        hit = k;
      if (!ledger[k].justified && (best < 0 || ledger[k].hours > ledger[best].hours))
        best = k;
    end
    case (r.kind)
      REQ_ADD: begin
        if (hit >= 0) begin
          // A merge keeps the stored flag and saturates the hour count.
          total = {1'b0, ledger[hit].hours} + r.hours;
          ledger[hit].hours = total[HOURS_W] ? HOURS_MAX : total[HOURS_W-1:0];
          rep.status = ST_OK;
          rep.rec = ledger[hit];
        end else if (ledger_fill < CAPACITY) begin
          ledger[ledger_fill] = '{justified: r.justified, hours: HOURS_W'(r.hours),
                                  day: r.key.day, month: r.key.month, year: r.key.year};
          rep.status = ST_APPENDED;
          rep.rec = ledger[ledger_fill];
          ledger_fill++;
        end else begin
          rep.status = ST_FULL;
        end
      end
      REQ_LOOKUP: begin
        if (hit >= 0) begin
          rep.status = ST_OK;
          rep.rec = ledger[hit];
        end
      end
      REQ_MAX: begin
        if (best >= 0) begin
          rep.status = ST_OK;
          rep.rec = ledger[best];
        end
      end
      default: ;
    endcase
    return rep;
  endfunction

  // ---------------------------------------------------------------------------
  // Checking: results must arrive in request order.
  // ---------------------------------------------------------------------------
  reply_t result_due [$];
  int     reqs_taken = 0;
  int     results_seen = 0;
  int     errors = 0;
  logic   req_taken = 1'b0;   // The offered request beat was accepted at the last rising edge.
  req_t   offer = '0;         // The request currently driven on the in_ channel.

  task automatic report_mismatch(string what, int got, int want);
    if (errors < PRINT_CAP)
      $display("result %0d: %s is %0d, should be %0d", results_seen, what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    reply_t want;
    rec_t   seen;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        seen = out_tdata[$bits(rec_t)-1:0];
        if (result_due.size() == 0) begin
          report_mismatch("status of a result beat with nothing pending", out_tuser, 0);
        end else begin
          want = result_due.pop_front();
          if (out_tuser != want.status)
            report_mismatch("status", out_tuser, want.status);
          if (seen.year != want.rec.year)
            report_mismatch("year", seen.year, want.rec.year);
          if (seen.month != want.rec.month)
            report_mismatch("month", seen.month, want.rec.month);
          if (seen.day != want.rec.day)
            report_mismatch("day", seen.day, want.rec.day);
          if (seen.hours != want.rec.hours)
            report_mismatch("hours", seen.hours, want.rec.hours);
          if (seen.justified != want.rec.justified)
            report_mismatch("justified", seen.justified, want.rec.justified);
        end
        results_seen <= results_seen + 1;
      end
      if (in_tvalid && in_tready) begin
        result_due.push_back(apply_request(offer));
        reqs_taken <= reqs_taken + 1;
      end
    end
    req_taken <= rst_n && in_tvalid && in_tready;
  end

  // Watchdog: a run that stops moving beats is a failure.
  int idle_cycles = 0;

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == IDLE_LIMIT) begin
      $display("tb_date_keyed_accumulate_table: FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Request driver: pops pending requests and offers them at the falling edge.
  // ---------------------------------------------------------------------------
  req_t pending [$];
  int   n_queued = 0;
  wire  calm = reqs_taken >= CALM_FROM && reqs_taken < CALM_TO;

  always @(negedge clk) begin
    req_t item;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || req_taken) begin
      // A held beat stays put; a new one goes out only once the previous one was taken.
      if (pending.size() != 0 && (calm || $urandom_range(99) >= 7)) begin
        item = pending.pop_front();
        offer     <= item;
        in_tvalid <= 1'b1;
        in_tuser  <= item.kind;
        in_tdata  <= {2'b00, item.justified, item.hours,
                      item.key.day, item.key.month, item.key.year};
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Result receiver: random back-pressure plus one long hold-off. The hold lets
  // both the sequencer and the output register fill so that in_tready drops.
  int   hold_left = 0;
  logic hold_done = 1'b0;

  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (!hold_done && reqs_taken == HOLD_AT) begin
      hold_done  <= 1'b1;
      hold_left  <= HOLD_CYCLES;
      out_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= calm || $urandom_range(99) >= 7;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus.
  // ---------------------------------------------------------------------------
  function automatic date_t any_date();
    return '{year: 12'($urandom_range(4095)), month: 4'($urandom_range(15)),
             day: 5'($urandom_range(31))};
  endfunction

  function automatic req_t make_req(logic [1:0] kind, date_t key, logic [ADD_W-1:0] hours,
                                    logic justified);
    return '{kind: kind, key: key, hours: hours, justified: justified};
  endfunction

  task automatic queue_req(req_t r);
    pending.push_back(r);
    n_queued++;
  endtask

  initial begin
    date_t pool [KEY_POOL];
    date_t top_key;
    date_t zero_key;
    date_t hot;
    int    pick;
    top_key  = '{year: 12'hFFF, month: 4'hF, day: 5'h1F};
    zero_key = '0;
    hot      = '{year: 12'h5A5, month: 4'd7, day: 5'd19};

    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    // Directed part. On an empty table every query misses.
    queue_req(make_req(REQ_MAX, zero_key, 8'd0, 1'b0));
    queue_req(make_req(REQ_LOOKUP, top_key, 8'd0, 1'b0));
    queue_req(make_req(REQ_UNUSED, zero_key, 8'd0, 1'b0));
    // A flagged record alone leaves the max query with nothing to return.
    queue_req(make_req(REQ_ADD, top_key, 8'hFF, 1'b1));
    queue_req(make_req(REQ_MAX, top_key, 8'hFF, 1'b1));
    queue_req(make_req(REQ_ADD, zero_key, 8'd0, 1'b0));
    queue_req(make_req(REQ_MAX, zero_key, 8'd0, 1'b0));
    // A merge adds hours and must keep the stored flag, not take the new one.
    queue_req(make_req(REQ_ADD, top_key, 8'hFF, 1'b0));
    queue_req(make_req(REQ_LOOKUP, top_key, 8'd0, 1'b0));
    // Two unflagged records with equal hours: the earlier one wins the max query.
    queue_req(make_req(REQ_ADD, '{12'd1234, 4'd2, 5'd29}, 8'd100, 1'b0));
    queue_req(make_req(REQ_ADD, '{12'd1100, 4'd12, 5'd1}, 8'd100, 1'b0));
    queue_req(make_req(REQ_MAX, zero_key, 8'd0, 1'b0));
    // Raising the oldest unflagged record to the same count moves the tie onto it.
    queue_req(make_req(REQ_ADD, zero_key, 8'd100, 1'b1));
    queue_req(make_req(REQ_MAX, zero_key, 8'd0, 1'b0));
    // Keys that differ in one field only must miss.
    queue_req(make_req(REQ_LOOKUP, '{12'd1234, 4'd2, 5'd28}, 8'd0, 1'b0));
    queue_req(make_req(REQ_LOOKUP, '{12'd1234, 4'd3, 5'd29}, 8'd0, 1'b0));
    queue_req(make_req(REQ_LOOKUP, '{12'd1235, 4'd2, 5'd29}, 8'd0, 1'b0));
    queue_req(make_req(REQ_UNUSED, top_key, 8'hFF, 1'b1));
    // Month and day values outside the calendar are plain keys.
    queue_req(make_req(REQ_ADD, '{12'h800, 4'd13, 5'd0}, 8'hAA, 1'b1));
    queue_req(make_req(REQ_LOOKUP, '{12'h800, 4'd13, 5'd0}, 8'd0, 1'b0));
    queue_req(make_req(REQ_ADD, '{12'h555, 4'd0, 5'd17}, 8'h55, 1'b0));
    queue_req(make_req(REQ_MAX, zero_key, 8'd0, 1'b0));

    // The sender pauses here until every directed result is back.
    while (reqs_taken != n_queued || result_due.size() != 0) @(negedge clk);

    // One flagged key takes almost every add, so its hours saturate;
    // the rest is noise of every kind.
    queue_req(make_req(REQ_ADD, hot, 8'hFF, 1'b1));
    for (int k = 1; k < HOT_ITEMS; k++) begin
      pick = $urandom_range(99);
      if (pick < 94)
        queue_req(make_req(REQ_ADD, hot, (k % 32 == 0) ? 8'($urandom_range(255)) : 8'hFF,
                           1'($urandom_range(1))));
      else if (pick < 97)
        queue_req(make_req(REQ_LOOKUP, hot, 8'($urandom_range(255)), 1'($urandom_range(1))));
      else
        queue_req(make_req(2'($urandom_range(3)), any_date(), 8'($urandom_range(255)),
                           1'($urandom_range(1))));
    end

    // Mixed traffic over a key pool larger than the table: merges, appends,
    // a full table, hits, misses and max queries over a growing set.
    for (int k = 0; k < KEY_POOL; k++)
      pool[k] = any_date();
    for (int k = 0; k < MIX_ITEMS; k++) begin
      pick = $urandom_range(99);
      if (pick < 45)
        queue_req(make_req(REQ_ADD, pool[$urandom_range(KEY_POOL - 1)],
                           8'($urandom_range(255)), 1'($urandom_range(1))));
      else if (pick < 70)
        queue_req(make_req(REQ_LOOKUP,
                           ($urandom_range(9) < 7) ? pool[$urandom_range(KEY_POOL - 1)]
                                                   : any_date(),
                           8'($urandom_range(255)), 1'($urandom_range(1))));
      else if (pick < 90)
        queue_req(make_req(REQ_MAX, any_date(), 8'($urandom_range(255)),
                           1'($urandom_range(1))));
      else if (pick < 95)
        queue_req(make_req(REQ_UNUSED, any_date(), 8'($urandom_range(255)),
                           1'($urandom_range(1))));
      else
        queue_req(make_req(REQ_ADD, any_date(), 8'($urandom_range(255)),
                           1'($urandom_range(1))));
    end

    // Wait for every request to go in and every result to come out, then let
    // the block run a full scan longer in case it emits something extra.
    while (reqs_taken != n_queued || result_due.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (errors == 0)
      $display("tb_date_keyed_accumulate_table: PASS");
    else
      $display("tb_date_keyed_accumulate_table: FAIL");
    $finish;
  end

endmodule

>>> sim.f
rtl/dkat_pkg.sv
rtl/date_keyed_accumulate_table.sv
tb/tb_date_keyed_accumulate_table.sv
